// ===== rtl/nhc_pkg.sv =====
package nhc_pkg;

    localparam int DEF_BUCKETS        = 64;
    localparam int DEF_WAYS           = 4;
    localparam int DEF_LIFETIME_TICKS = 120;

    localparam logic [15:0] LINK_BLK_RESET = 16'd1498;
    localparam logic [47:0] DERIVED_MAC_BASE = 48'hAA0004000000;

    typedef enum logic [2:0] {
        CMD_LOOKUP      = 3'd0,
        CMD_UPDATE      = 3'd1,
        CMD_UPDATE_HOLD = 3'd2,
        CMD_HOLD        = 3'd3,
        CMD_RELEASE     = 3'd4,
        CMD_TRYHARD     = 3'd5,
        CMD_TICK        = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        REG_ROUTER_PRESENT = 3'd0,
        REG_ROUTER_NODE    = 3'd1,
        REG_ROUTER_MAC     = 3'd2,
        REG_ROUTER_BLK     = 3'd3,
        REG_LINK_BLK       = 3'd4,
        REG_PRIME_MODE     = 3'd5,
        REG_UNKNOWN_MAC    = 3'd6
    } reg_idx_t;

    // One cache entry as stored in the entry memory
    typedef struct packed {
        logic [15:0] node;
        logic [47:0] mac;
        logic        on_link;
        logic [15:0] blk;
        logic [6:0]  life;
        logic [7:0]  refs;
    } entry_t;

    // Configuration bundle
    typedef struct packed {
        logic        router_present;
        logic [15:0] router_node;
        logic [47:0] router_mac;
        logic [15:0] router_blk;
        logic [15:0] link_blk;
        logic        prime_mode;
        logic [47:0] unknown_mac;
    } cfg_t;

    function automatic logic [47:0] derive_mac(input logic [15:0] a);
        derive_mac = DERIVED_MAC_BASE | {32'd0, a[7:0], a[15:8]};
    endfunction

endpackage

// ===== rtl/nhc_cfg_regs.sv =====
module nhc_cfg_regs
    import nhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{router_present: 1'b0,
                         router_node:    16'd0,
                         router_mac:     48'd0,
                         router_blk:     16'd0,
                         link_blk:       LINK_BLK_RESET,
                         prime_mode:     1'b0,
                         unknown_mac:    48'd0};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROUTER_PRESENT: cfg_reg.router_present <= cfg_data[0];
                REG_ROUTER_NODE:    cfg_reg.router_node    <= cfg_data[15:0];
                REG_ROUTER_MAC:     cfg_reg.router_mac     <= cfg_data;
                REG_ROUTER_BLK:     cfg_reg.router_blk     <= cfg_data[15:0];
                REG_LINK_BLK:       cfg_reg.link_blk       <= cfg_data[15:0];
                REG_PRIME_MODE:     cfg_reg.prime_mode     <= cfg_data[0];
                REG_UNKNOWN_MAC:    cfg_reg.unknown_mac    <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/nhc_entry_ram.sv =====
module nhc_entry_ram
    import nhc_pkg::*;
#(
    parameter int DEPTH = DEF_BUCKETS * DEF_WAYS,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/nexthop_neighbor_cache_unit.sv =====
// Channel  | Ports                                          | Handshake
// ---------+------------------------------------------------+---------------------------
// command  | cmd node_addr mac_in mac_given on_link_in      | start high, busy low
// result   | ok mac_out on_link_out block_size_out          | done high for one cycle
// config   | cfg_we cfg_index cfg_data                      | cfg_we high, no wait
//
// A command scans its bucket one way per cycle through the entry memory (one read
// port, registered read). On a hit or an allocation the entry is then read back,
// modified and written; otherwise nothing is written back.
// A tick walks every entry, one read-modify-write a cycle.
// Valid bits sit in flip-flops that reset clears; the memory itself needs no clear.
// busy is high from acceptance until the done cycle; the receiver cannot stall the result.
module nexthop_neighbor_cache_unit
    import nhc_pkg::*;
#(
    parameter int BUCKETS        = DEF_BUCKETS,
    parameter int WAYS           = DEF_WAYS,
    parameter int LIFETIME_TICKS = DEF_LIFETIME_TICKS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [15:0] node_addr,
    input  logic [47:0] mac_in,
    input  logic        mac_given,
    input  logic        on_link_in,
    output logic        done,
    output logic        ok,
    output logic [47:0] mac_out,
    output logic        on_link_out,
    output logic [15:0] block_size_out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    localparam int NENT = BUCKETS * WAYS;
    localparam int AW   = (NENT > 1) ? $clog2(NENT) : 1;
    localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [6:0] LIFE = 7'(LIFETIME_TICKS);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_DECIDE= 6'b000100,
        ST_RD    = 6'b001000,
        ST_MOD   = 6'b010000,
        ST_TICK  = 6'b100000
    } state_t;

    cfg_t cfg;

    nhc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    state_t state_reg, state_next;
    logic [NENT-1:0] valid_reg;
    logic [2:0]  cmd_reg;
    logic [15:0] addr_reg;
    logic [47:0] mac_reg;
    logic        given_reg;
    logic        onl_reg;
    logic [WW:0] way_reg;      // issued read way
    logic        rvld_reg;     // read data valid for chk_way_reg
    logic [WW-1:0] chk_way_reg;
    logic        hit_reg;
    logic [WW-1:0] hit_way_reg;
    logic        free_reg;
    logic [WW-1:0] free_way_reg;
    logic [AW:0] tk_reg;       // tick read pointer
    logic        tvld_reg;
    logic [AW-1:0] tk_addr_reg;
    logic        done_reg;
    logic        ok_reg;
    logic [47:0] mac_out_reg;
    logic        onl_out_reg;
    logic [15:0] blk_out_reg;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    entry_t        rd_data, wr_data;

    nhc_entry_ram #(.DEPTH(NENT)) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    logic [BW-1:0] bucket;
    logic [AW-1:0] base;
    assign bucket = (BUCKETS > 1) ? BW'(addr_reg % BUCKETS) : '0;
    assign base   = AW'(32'(bucket) * WAYS);

    function automatic logic [AW-1:0] way_addr(input logic [AW-1:0] b, input logic [WW-1:0] w);
        way_addr = b + AW'(w);
    endfunction

    logic is_upd;
    assign is_upd = (cmd_reg == CMD_UPDATE) || (cmd_reg == CMD_UPDATE_HOLD);

    // Entry computed for a modify step
    entry_t mod_e;
    logic   is_rtr;
    always_comb
    begin
        mod_e  = rd_data;
        is_rtr = 1'b0;
        if (!hit_reg)
        begin
            mod_e.node    = addr_reg;
            mod_e.refs    = 8'd1;
            mod_e.life    = LIFE;
            mod_e.blk     = cfg.link_blk;
            mod_e.on_link = onl_reg;
            if (given_reg)
                mod_e.mac = mac_reg;
            else if (cfg.router_present)
            begin
                mod_e.on_link = 1'b0;
                mod_e.mac     = cfg.router_mac;
                mod_e.blk     = cfg.router_blk;
            end
            else
            begin
                mod_e.on_link = 1'b1;
                mod_e.mac     = cfg.prime_mode ? cfg.unknown_mac : derive_mac(addr_reg);
            end
        end
        is_rtr = cfg.router_present && (mod_e.node == cfg.router_node);
        case (cmd_reg)
            CMD_UPDATE, CMD_UPDATE_HOLD:
            begin
                if (hit_reg)
                begin
                    mod_e.life    = LIFE;
                    mod_e.on_link = onl_reg;
                    if (given_reg)
                        mod_e.mac = mac_reg;
                end
                else
                    mod_e.on_link = mod_e.on_link;
                if (cmd_reg == CMD_UPDATE_HOLD)
                    mod_e.on_link = onl_reg;
                if (!is_rtr && onl_reg)
                    mod_e.blk = cfg.link_blk;
                if (cmd_reg == CMD_UPDATE_HOLD && mod_e.refs != 8'hFF)
                    mod_e.refs = mod_e.refs + 8'd1;
            end
            CMD_HOLD:
                if (mod_e.refs != 8'hFF)
                    mod_e.refs = mod_e.refs + 8'd1;
            CMD_RELEASE:
                if (mod_e.refs > 8'd1)
                    mod_e.refs = mod_e.refs - 8'd1;
            CMD_TRYHARD:
                if (cfg.router_present)
                begin
                    mod_e.on_link = 1'b0;
                    mod_e.mac     = cfg.router_mac;
                end
                else
                begin
                    mod_e.on_link = 1'b1;
                    mod_e.mac     = cfg.prime_mode ? cfg.unknown_mac : derive_mac(rd_data.node);
                end
            default: ;
        endcase
    end

    logic [WW-1:0] tgt_way;
    assign tgt_way = hit_reg ? hit_way_reg : free_way_reg;

    // Memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = base;
        wr_en   = 1'b0;
        wr_addr = way_addr(base, tgt_way);
        wr_data = mod_e;
        if (state_reg == ST_SCAN && way_reg < (WW+1)'(WAYS))
        begin
            rd_en   = 1'b1;
            rd_addr = way_addr(base, way_reg[WW-1:0]);
        end
        else if (state_reg == ST_RD)
        begin
            rd_en   = 1'b1;
            rd_addr = way_addr(base, tgt_way);
        end
        else if (state_reg == ST_MOD)
        begin
            wr_en = hit_reg || (is_upd && free_reg);
        end
        else if (state_reg == ST_TICK)
        begin
            rd_en   = tk_reg < (AW+1)'(NENT);
            rd_addr = tk_reg[AW-1:0];
            wr_addr = tk_addr_reg;
            wr_data = rd_data;
            wr_data.life = rd_data.life - 7'd1;
            wr_en   = tvld_reg && valid_reg[tk_addr_reg] && (rd_data.life != 7'd0);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = (cmd == CMD_TICK) ? ST_TICK : ST_SCAN;
            ST_SCAN:
                if (way_reg >= (WW+1)'(WAYS) && !rvld_reg)
                    state_next = ST_DECIDE;
            ST_DECIDE:
                state_next = (hit_reg || (is_upd && free_reg)) ? ST_RD : ST_MOD;
            ST_RD:
                state_next = ST_MOD;
            ST_MOD:
                state_next = ST_IDLE;
            ST_TICK:
                if (tk_reg >= (AW+1)'(NENT) && !tvld_reg)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    logic cmd_known;
    assign cmd_known = (cmd_reg <= CMD_TRYHARD);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            rvld_reg  <= 1'b0;
            tvld_reg  <= 1'b0;
            done_reg  <= 1'b0;
            way_reg   <= '0;
            tk_reg    <= '0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            rvld_reg  <= 1'b0;
            tvld_reg  <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    way_reg  <= '0;
                    tk_reg   <= '0;
                    hit_reg  <= 1'b0;
                    free_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    if (way_reg < (WW+1)'(WAYS))
                    begin
                        rvld_reg    <= 1'b1;
                        chk_way_reg <= way_reg[WW-1:0];
                        way_reg     <= way_reg + 1'b1;
                    end
                    if (rvld_reg)
                    begin
                        if (valid_reg[way_addr(base, chk_way_reg)])
                        begin
                            if (rd_data.node == addr_reg && !hit_reg)
                            begin
                                hit_reg     <= 1'b1;
                                hit_way_reg <= chk_way_reg;
                            end
                        end
                        else if (!free_reg)
                        begin
                            free_reg     <= 1'b1;
                            free_way_reg <= chk_way_reg;
                        end
                    end
                end
                ST_MOD:
                begin
                    done_reg <= 1'b1;
                    if (wr_en)
                        valid_reg[wr_addr] <= 1'b1;
                end
                ST_TICK:
                begin
                    if (rd_en)
                    begin
                        tvld_reg    <= 1'b1;
                        tk_addr_reg <= tk_reg[AW-1:0];
                        tk_reg      <= tk_reg + 1'b1;
                    end
                    if (tvld_reg && rd_data.life == 7'd0 && rd_data.refs == 8'd1)
                        valid_reg[tk_addr_reg] <= 1'b0;
                    if (state_next == ST_IDLE)
                        done_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Capture command and form result
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            cmd_reg   <= cmd;
            addr_reg  <= node_addr;
            mac_reg   <= mac_in;
            given_reg <= mac_given;
            onl_reg   <= on_link_in;
        end
        if (state_reg == ST_MOD)
        begin
            ok_reg      <= cmd_known && wr_en;
            mac_out_reg <= (cmd_known && wr_en) ? mod_e.mac : '0;
            onl_out_reg <= (cmd_known && wr_en) && mod_e.on_link;
            blk_out_reg <= (cmd_known && wr_en) ? mod_e.blk : '0;
        end
        else if (state_reg == ST_TICK)
        begin
            ok_reg      <= 1'b1;
            mac_out_reg <= '0;
            onl_out_reg <= 1'b0;
            blk_out_reg <= '0;
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign ok             = ok_reg;
    assign mac_out        = mac_out_reg;
    assign on_link_out    = onl_out_reg;
    assign block_size_out = blk_out_reg;

    // A done pulse is only raised after the modify or tick state
    property p_done_from_work;
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_MOD || state_reg == ST_TICK);
    endproperty
    a_done_from_work: assert property (p_done_from_work) else $error("stray done");

    property p_one_hot;
        @(posedge clk) disable iff (!rst_n) $onehot(state_reg);
    endproperty
    a_one_hot: assert property (p_one_hot) else $error("state not one-hot");

    property p_no_write_idle;
        @(posedge clk) disable iff (!rst_n) (state_reg == ST_IDLE) |-> !wr_en;
    endproperty
    a_no_write_idle: assert property (p_no_write_idle) else $error("write while idle");

endmodule
